@@ rtl/core/ubhs_pkg.sv @@
// shared types, codes and constants of the bootloader host sequencer
package ubhs_pkg;

  // command codes of an input word
  localparam logic [1:0] CMD_BEGIN   = 2'd0;
  localparam logic [1:0] CMD_RX_BYTE = 2'd1;
  localparam logic [1:0] CMD_ADVANCE = 2'd2;

  // operation codes
  localparam logic [3:0] OP_SYNC      = 4'd0;
  localparam logic [3:0] OP_GET       = 4'd1;
  localparam logic [3:0] OP_GETVER    = 4'd2;
  localparam logic [3:0] OP_GETID     = 4'd3;
  localparam logic [3:0] OP_READ      = 4'd4;
  localparam logic [3:0] OP_GO        = 4'd5;
  localparam logic [3:0] OP_WRITE     = 4'd6;
  localparam logic [3:0] OP_ERASE     = 4'd7;
  localparam logic [3:0] OP_UNPROTECT = 4'd8;
  localparam logic [3:0] OP_LAST      = OP_UNPROTECT;

  // status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_NACK       = 2'd1;
  localparam logic [1:0] ST_UNEXPECTED = 2'd2;

  // protocol bytes
  localparam logic [7:0] SYNC_BYTE         = 8'h7F;
  localparam logic [7:0] ACK_RESET         = 8'h79;
  localparam logic [7:0] GLOBAL_ERASE_CNT  = 8'hFF;
  localparam logic [7:0] GLOBAL_ERASE_TAIL = 8'h00;
  localparam logic [31:0] GO_OFFSET        = 32'd4;

  // most result words one input word can cause
  localparam int unsigned MaxRes = 5;
  localparam int unsigned ResIdxW = $clog2(MaxRes);
  localparam int unsigned ResCntW = $clog2(MaxRes + 1);

  typedef struct packed {
    logic [1:0]  command;
    logic [3:0]  operation;
    logic [31:0] target_address;
    logic [7:0]  byte_count;
    logic [7:0]  byte_value;
  } in_item_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       data_valid;
    logic [7:0] data_byte;
    logic       done_res;
    logic [1:0] status;
    logic       last;
  } out_item_t;

  typedef logic [7:0] cfg_item_t;

  // opcode sent for each operation
  function automatic logic [7:0] opcode_of(input logic [3:0] op);
    logic [7:0] code;
    case (op)
      OP_SYNC:      code = SYNC_BYTE;
      OP_GET:       code = 8'h00;
      OP_GETVER:    code = 8'h01;
      OP_GETID:     code = 8'h02;
      OP_READ:      code = 8'h11;
      OP_GO:        code = 8'h21;
      OP_WRITE:     code = 8'h31;
      OP_ERASE:     code = 8'h43;
      OP_UNPROTECT: code = 8'h73;
      default:      code = 8'h00;
    endcase
    return code;
  endfunction

  // result word that transmits one byte
  function automatic out_item_t tx_word(input logic [7:0] b);
    out_item_t r;
    r = '0;
    r.tx_valid = 1'b1;
    r.tx_byte  = b;
    return r;
  endfunction

  // result word that ends the operation
  function automatic out_item_t done_word(input logic [1:0] st);
    out_item_t r;
    r = '0;
    r.done_res = 1'b1;
    r.status   = st;
    return r;
  endfunction

  // result word that carries a returned byte
  function automatic out_item_t data_word(input logic [7:0] b, input logic done);
    out_item_t r;
    r = '0;
    r.data_valid = 1'b1;
    r.data_byte  = b;
    r.done_res   = done;
    return r;
  endfunction

endpackage

@@ rtl/core/ubhs_chan_if.sv @@
// valid/ready channel carrying one word of a given payload type
interface ubhs_chan_if #(
  parameter type payload_t = logic [7:0]
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/core/uart_bootloader_host_sequencer_top.sv @@
// host sequencer for a serial rom bootloader: phase logic and result buffer
//
//  channel   | dir | word                         | accepted when
//  ----------+-----+------------------------------+-----------------------
//  in_chan   | in  | command, operation, address, | valid & ready
//            |     | count, byte value            |
//  out_chan  | out | tx, data, done, status, last | valid & ready
//  cfg_chan  | in  | ack byte                     | valid & ready (ready=1)
//
// every input word is decoded in the cycle it is accepted; its zero to five
// result words are loaded into the result buffer and leave one per cycle
// while the output is ready. a word holds the input until its last result
// leaves: the next word is taken in the same cycle as that last result.
// output stalls hold the buffer and so the input; reset returns to idle with
// the ack byte at 0x79.
module uart_bootloader_host_sequencer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  ubhs_chan_if.sink   in_chan,
  ubhs_chan_if.source out_chan,
  ubhs_chan_if.sink   cfg_chan
);
  import ubhs_pkg::*;

  typedef enum logic [3:0] {
    PhIdle,
    PhCmdAck,
    PhAddrAck,
    PhCountAck,
    PhRxCount,
    PhRxData,
    PhFinalAck,
    PhTxPayload,
    PhTxPages
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [3:0]  op_q, op_d;
  logic [31:0] addr_q, addr_d;
  logic [7:0]  count_q, count_d;
  logic [8:0]  prog_q, prog_d;
  logic [7:0]  csum_q, csum_d;
  logic [7:0]  ack_q;

  out_item_t          res_q [MaxRes];
  out_item_t          res_d [MaxRes];
  logic [ResCntW-1:0] cnt_q, n_d;
  logic [ResIdxW-1:0] idx_q;

  in_item_t   it;
  logic       ok;
  logic       err;
  logic       prog_end;
  logic [7:0] adv_b;
  logic [7:0] csum_x;
  logic [7:0] opc;
  logic       in_fire, out_fire, out_last;

  assign it       = in_chan.payload;
  assign ok       = (it.byte_value == ack_q);
  assign prog_end = (prog_q >= {1'b0, count_q});
  assign opc      = opcode_of(it.operation);

  // handshake: input taken once the buffer drains its last word
  assign out_chan.valid   = (cnt_q != '0);
  assign out_chan.payload = res_q[idx_q];
  assign out_last         = res_q[idx_q].last;
  assign out_fire         = out_chan.valid & out_chan.ready;
  assign in_chan.ready    = !out_chan.valid | (out_chan.ready & out_last);
  assign in_fire          = in_chan.valid & in_chan.ready;
  assign cfg_chan.ready   = 1'b1;

  // phase decode and result words for one input word
  always_comb begin
    phase_d = phase_q;
    op_d    = op_q;
    addr_d  = addr_q;
    count_d = count_q;
    prog_d  = prog_q;
    csum_d  = csum_q;
    n_d     = '0;
    err     = 1'b0;
    adv_b   = it.byte_value;
    csum_x  = '0;
    for (int i = 0; i < MaxRes; i++) begin
      res_d[i] = '0;
    end
    case (it.command)
      CMD_BEGIN: begin
        if (phase_q == PhIdle && it.operation <= OP_LAST) begin
          op_d    = it.operation;
          addr_d  = (it.operation == OP_GO) ? 32'(it.target_address - GO_OFFSET)
                                            : it.target_address;
          count_d = it.byte_count;
          prog_d  = '0;
          csum_d  = '0;
          phase_d = PhCmdAck;
          res_d[0] = tx_word(opc);
          res_d[1] = tx_word(~opc);
          n_d = (it.operation == OP_SYNC) ? ResCntW'(1) : ResCntW'(2);
        end else begin
          err = 1'b1;
        end
      end
      CMD_RX_BYTE: begin
        case (phase_q)
          PhCmdAck: begin
            if (!ok) begin
              res_d[0] = done_word(ST_NACK);
              n_d      = ResCntW'(1);
              phase_d  = PhIdle;
            end else begin
              case (op_q)
                OP_SYNC: begin
                  res_d[0] = done_word(ST_OK);
                  n_d      = ResCntW'(1);
                  phase_d  = PhIdle;
                end
                OP_GET, OP_GETID: phase_d = PhRxCount;
                OP_GETVER: begin
                  count_d = 8'd2;
                  prog_d  = '0;
                  phase_d = PhRxData;
                end
                OP_READ, OP_GO, OP_WRITE: begin
                  phase_d  = PhAddrAck;
                  res_d[0] = tx_word(addr_q[31:24]);
                  res_d[1] = tx_word(addr_q[23:16]);
                  res_d[2] = tx_word(addr_q[15:8]);
                  res_d[3] = tx_word(addr_q[7:0]);
                  res_d[4] = tx_word(addr_q[31:24] ^ addr_q[23:16] ^
                                     addr_q[15:8] ^ addr_q[7:0]);
                  n_d      = ResCntW'(5);
                end
                OP_ERASE: begin
                  if (count_q == GLOBAL_ERASE_CNT) begin
                    res_d[0] = tx_word(GLOBAL_ERASE_CNT);
                    res_d[1] = tx_word(GLOBAL_ERASE_TAIL);
                    n_d      = ResCntW'(2);
                    phase_d  = PhFinalAck;
                  end else begin
                    csum_d   = count_q;
                    prog_d   = '0;
                    phase_d  = PhTxPages;
                    res_d[0] = tx_word(count_q);
                    n_d      = ResCntW'(1);
                  end
                end
                default: phase_d = PhFinalAck;
              endcase
            end
          end
          PhAddrAck: begin
            if (!ok) begin
              res_d[0] = done_word(ST_NACK);
              n_d      = ResCntW'(1);
              phase_d  = PhIdle;
            end else if (op_q == OP_READ) begin
              res_d[0] = tx_word(count_q);
              res_d[1] = tx_word(~count_q);
              n_d      = ResCntW'(2);
              phase_d  = PhCountAck;
            end else if (op_q == OP_WRITE) begin
              csum_d   = count_q;
              prog_d   = '0;
              phase_d  = PhTxPayload;
              res_d[0] = tx_word(count_q);
              n_d      = ResCntW'(1);
            end else begin
              res_d[0] = done_word(ST_OK);
              n_d      = ResCntW'(1);
              phase_d  = PhIdle;
            end
          end
          PhCountAck: begin
            if (!ok) begin
              res_d[0] = done_word(ST_NACK);
              n_d      = ResCntW'(1);
              phase_d  = PhIdle;
            end else begin
              prog_d  = '0;
              phase_d = PhRxData;
            end
          end
          PhRxCount: begin
            count_d = it.byte_value;
            prog_d  = '0;
            phase_d = PhRxData;
          end
          PhRxData: begin
            n_d = ResCntW'(1);
            if (prog_end) begin
              if (op_q == OP_READ) begin
                res_d[0] = data_word(it.byte_value, 1'b1);
                phase_d  = PhIdle;
              end else begin
                res_d[0] = data_word(it.byte_value, 1'b0);
                phase_d  = PhFinalAck;
              end
            end else begin
              res_d[0] = data_word(it.byte_value, 1'b0);
              prog_d   = 9'(prog_q + 9'd1);
            end
          end
          PhFinalAck: begin
            res_d[0] = done_word(ok ? ST_OK : ST_NACK);
            n_d      = ResCntW'(1);
            phase_d  = PhIdle;
          end
          default: err = 1'b1;
        endcase
      end
      CMD_ADVANCE: begin
        if (phase_q == PhTxPayload || phase_q == PhTxPages) begin
          adv_b    = (phase_q == PhTxPages) ? prog_q[7:0] : it.byte_value;
          csum_x   = csum_q ^ adv_b;
          csum_d   = csum_x;
          res_d[0] = tx_word(adv_b);
          if (prog_end) begin
            res_d[1] = tx_word(csum_x);
            n_d      = ResCntW'(2);
            phase_d  = PhFinalAck;
          end else begin
            n_d    = ResCntW'(1);
            prog_d = 9'(prog_q + 9'd1);
          end
        end else begin
          err = 1'b1;
        end
      end
      default: err = 1'b1;
    endcase
    // unexpected word: one status word, state untouched
    if (err) begin
      phase_d  = phase_q;
      op_d     = op_q;
      addr_d   = addr_q;
      count_d  = count_q;
      prog_d   = prog_q;
      csum_d   = csum_q;
      res_d[0] = '0;
      res_d[0].status = ST_UNEXPECTED;
      n_d      = ResCntW'(1);
    end
    // mark the final word of this input
    for (int i = 0; i < MaxRes; i++) begin
      if (ResCntW'(i + 1) == n_d) begin
        res_d[i].last = 1'b1;
      end
    end
  end

  // sequencer state and ack register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      op_q    <= '0;
      addr_q  <= '0;
      count_q <= '0;
      prog_q  <= '0;
      csum_q  <= '0;
      ack_q   <= ACK_RESET;
    end else begin
      if (in_fire) begin
        phase_q <= phase_d;
        op_q    <= op_d;
        addr_q  <= addr_d;
        count_q <= count_d;
        prog_q  <= prog_d;
        csum_q  <= csum_d;
      end
      if (cfg_chan.valid) begin
        ack_q <= cfg_chan.payload;
      end
    end
  end

  // result buffer fill and drain control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      idx_q <= '0;
    end else begin
      if (in_fire) begin
        cnt_q <= n_d;
        idx_q <= '0;
      end else if (out_fire) begin
        if (out_last) begin
          cnt_q <= '0;
          idx_q <= '0;
        end else begin
          idx_q <= ResIdxW'(idx_q + 1'b1);
        end
      end
    end
  end

  // result buffer words
  always_ff @(posedge clk_i) begin
    if (in_fire && n_d != '0) begin
      for (int i = 0; i < MaxRes; i++) begin
        res_q[i] <= res_d[i];
      end
    end
  end

endmodule

@@ rtl/core/ubhs_checker.sv @@
// port-level assertions for the bootloader host sequencer, with its bind
module ubhs_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_ready_i,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input ubhs_pkg::out_item_t out_word_i
);
  import ubhs_pkg::*;

  // input waits while a word that is not the last one is pending
  a_hold_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_word_i.last |-> !in_ready_i)
    else $error("input taken before results of previous word drained");

  // a stalled result word holds
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_word_i))
    else $error("stalled result word changed");

  // an unexpected-word status stands alone with nothing valid
  a_unexpected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_word_i.status == ST_UNEXPECTED |->
      out_word_i.last && !out_word_i.tx_valid && !out_word_i.data_valid &&
      !out_word_i.done_res)
    else $error("malformed unexpected-word result");

  // a transmit word never finishes and carries no status
  a_tx_plain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_word_i.tx_valid |->
      !out_word_i.done_res && !out_word_i.data_valid && out_word_i.status == ST_OK)
    else $error("transmit word mixed with completion");

endmodule

bind uart_bootloader_host_sequencer_top ubhs_checker u_ubhs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_chan.ready),
  .out_valid_i (out_chan.valid),
  .out_ready_i (out_chan.ready),
  .out_word_i  (out_chan.payload)
);

@@ bench/ubhs_result_checker.sv @@
// result checker: predicts the sequencer's result words and compares them as they leave
`timescale 1ns / 100ps

module ubhs_result_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  ubhs_pkg::in_item_t  in_word_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  ubhs_pkg::out_item_t out_word_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  ubhs_pkg::cfg_item_t cfg_ack_i,
  output int unsigned         mismatches_o,
  output int unsigned         pending_o,
  output int unsigned         checked_o
);
  import ubhs_pkg::*;

  localparam int unsigned ReportLimit = 10;

  // version, then two option bytes, counted from zero
  localparam logic [7:0] GETVER_LAST = 8'd2;

  // opcode byte of each operation, indexed by operation code
  localparam logic [8:0][7:0] OPCODE_BYTES = {
    8'h73, 8'h43, 8'h31, 8'h21, 8'h11, 8'h02, 8'h01, 8'h00, SYNC_BYTE
  };

  typedef enum logic [4:0] {
    PH_IDLE,
    PH_CMD_ACK,
    PH_ADDR_ACK,
    PH_COUNT_ACK,
    PH_RX_COUNT,
    PH_RX_DATA,
    PH_FINAL_ACK,
    PH_TX_PAYLOAD,
    PH_TX_PAGES
  } seq_phase_e;

  // predicted sequencer state
  seq_phase_e  phase_q;
  logic [3:0]  op_q;
  logic [31:0] addr_q;
  logic [7:0]  count_q;
  logic [8:0]  index_q;
  logic [7:0]  csum_q;
  logic [7:0]  ack_q;

  out_item_t   burst_words [$];
  out_item_t   due_words [$];

  function automatic out_item_t res_word(input logic txv, input logic [7:0] txb,
                                         input logic dv, input logic [7:0] db,
                                         input logic done, input logic [1:0] st);
    out_item_t r;
    r.tx_valid   = txv;
    r.tx_byte    = txb;
    r.data_valid = dv;
    r.data_byte  = db;
    r.done_res   = done;
    r.status     = st;
    r.last       = 1'b0;
    return r;
  endfunction

  function automatic string word_text(input out_item_t w);
    return $sformatf("tx %0b/%02h data %0b/%02h done %0b status %0d last %0b",
                     w.tx_valid, w.tx_byte, w.data_valid, w.data_byte,
                     w.done_res, w.status, w.last);
  endfunction

  task automatic push_tx(input logic [7:0] b);
    burst_words.push_back(res_word(1'b1, b, 1'b0, 8'h00, 1'b0, ST_OK));
  endtask

  task automatic push_data(input logic [7:0] b, input logic done);
    burst_words.push_back(res_word(1'b0, 8'h00, 1'b1, b, done, ST_OK));
  endtask

  task automatic finish_op(input logic [1:0] st);
    phase_q = PH_IDLE;
    burst_words.push_back(res_word(1'b0, 8'h00, 1'b0, 8'h00, 1'b1, st));
  endtask

  // advance the predicted state by one input word and queue the words it causes
  task automatic sequence_word(input in_item_t w);
    out_item_t  r;
    logic [7:0] b;
    logic       ok;
    logic       bad;
    bad = 1'b0;
    ok  = (w.byte_value == ack_q);
    case (w.command)
      CMD_BEGIN: begin
        if (phase_q == PH_IDLE && w.operation <= OP_LAST) begin
          op_q    = w.operation;
          addr_q  = (w.operation == OP_GO) ? w.target_address - GO_OFFSET
                                           : w.target_address;
          count_q = w.byte_count;
          index_q = '0;
          csum_q  = '0;
          phase_q = PH_CMD_ACK;
          push_tx(OPCODE_BYTES[w.operation]);
          if (w.operation != OP_SYNC) push_tx(~OPCODE_BYTES[w.operation]);
        end else begin
          bad = 1'b1;
        end
      end
      CMD_RX_BYTE: begin
        case (phase_q)
          PH_CMD_ACK: begin
            if (!ok) begin
              finish_op(ST_NACK);
            end else begin
              case (op_q)
                OP_SYNC: finish_op(ST_OK);
                OP_GET, OP_GETID: phase_q = PH_RX_COUNT;
                OP_GETVER: begin
                  count_q = GETVER_LAST;
                  index_q = '0;
                  phase_q = PH_RX_DATA;
                end
                OP_READ, OP_GO, OP_WRITE: begin
                  phase_q = PH_ADDR_ACK;
                  push_tx(addr_q[31:24]);
                  push_tx(addr_q[23:16]);
                  push_tx(addr_q[15:8]);
                  push_tx(addr_q[7:0]);
                  push_tx(addr_q[31:24] ^ addr_q[23:16] ^ addr_q[15:8] ^ addr_q[7:0]);
                end
                OP_ERASE: begin
                  if (count_q == GLOBAL_ERASE_CNT) begin
                    push_tx(GLOBAL_ERASE_CNT);
                    push_tx(GLOBAL_ERASE_TAIL);
                    phase_q = PH_FINAL_ACK;
                  end else begin
                    csum_q  = count_q;
                    index_q = '0;
                    phase_q = PH_TX_PAGES;
                    push_tx(count_q);
                  end
                end
                default: phase_q = PH_FINAL_ACK;
              endcase
            end
          end
          PH_ADDR_ACK: begin
            if (!ok) begin
              finish_op(ST_NACK);
            end else if (op_q == OP_READ) begin
              push_tx(count_q);
              push_tx(~count_q);
              phase_q = PH_COUNT_ACK;
            end else if (op_q == OP_WRITE) begin
              csum_q  = count_q;
              index_q = '0;
              phase_q = PH_TX_PAYLOAD;
              push_tx(count_q);
            end else begin
              finish_op(ST_OK);
            end
          end
          PH_COUNT_ACK: begin
            if (!ok) begin
              finish_op(ST_NACK);
            end else begin
              index_q = '0;
              phase_q = PH_RX_DATA;
            end
          end
          PH_RX_COUNT: begin
            count_q = w.byte_value;
            index_q = '0;
            phase_q = PH_RX_DATA;
          end
          PH_RX_DATA: begin
            if (index_q >= {1'b0, count_q}) begin
              if (op_q == OP_READ) begin
                phase_q = PH_IDLE;
                push_data(w.byte_value, 1'b1);
              end else begin
                phase_q = PH_FINAL_ACK;
                push_data(w.byte_value, 1'b0);
              end
            end else begin
              index_q = index_q + 9'd1;
              push_data(w.byte_value, 1'b0);
            end
          end
          PH_FINAL_ACK: finish_op(ok ? ST_OK : ST_NACK);
          default: bad = 1'b1;
        endcase
      end
      CMD_ADVANCE: begin
        if (phase_q == PH_TX_PAYLOAD || phase_q == PH_TX_PAGES) begin
          b      = (phase_q == PH_TX_PAYLOAD) ? w.byte_value : index_q[7:0];
          csum_q = csum_q ^ b;
          push_tx(b);
          if (index_q >= {1'b0, count_q}) begin
            push_tx(csum_q);
            phase_q = PH_FINAL_ACK;
          end else begin
            index_q = index_q + 9'd1;
          end
        end else begin
          bad = 1'b1;
        end
      end
      default: bad = 1'b1;
    endcase

    if (bad) burst_words.push_back(res_word(1'b0, 8'h00, 1'b0, 8'h00, 1'b0, ST_UNEXPECTED));

    // mark the last word of the burst, then hand it to the ordered store
    if (burst_words.size() != 0) begin
      r = burst_words.pop_back();
      r.last = 1'b1;
      burst_words.push_back(r);
    end
    while (burst_words.size() != 0) due_words.push_back(burst_words.pop_front());
  endtask

  // compare one accepted result word with the oldest prediction
  task automatic compare_word(input out_item_t got);
    out_item_t want;
    if (due_words.size() == 0) begin
      if (mismatches_o < ReportLimit)
        $display("[%0t] mismatch: result word with none predicted: %s", $time, word_text(got));
      mismatches_o++;
    end else begin
      want = due_words.pop_front();
      checked_o++;
      if (got.tx_valid !== want.tx_valid || got.tx_byte !== want.tx_byte ||
          got.data_valid !== want.data_valid || got.data_byte !== want.data_byte ||
          got.done_res !== want.done_res || got.status !== want.status ||
          got.last !== want.last) begin
        if (mismatches_o < ReportLimit) begin
          $display("[%0t] mismatch on result word %0d", $time, checked_o);
          $display("  expected %s", word_text(want));
          $display("  actual   %s", word_text(got));
        end
        mismatches_o++;
      end
    end
  endtask

  // watch the three channels at each edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q = PH_IDLE;
      op_q    = '0;
      addr_q  = '0;
      count_q = '0;
      index_q = '0;
      csum_q  = '0;
      ack_q   = ACK_RESET;
      burst_words.delete();
      due_words.delete();
      mismatches_o = 0;
      checked_o    = 0;
      pending_o    = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) ack_q = cfg_ack_i;
      if (in_valid_i && in_ready_i) sequence_word(in_word_i);
      if (out_valid_i && out_ready_i) compare_word(out_word_i);
      pending_o = due_words.size();
    end
  end

endmodule

@@ bench/tb_uart_bootloader_host_sequencer_top.sv @@
// bench top: clock, reset, protocol stimulus and verdict for the bootloader host sequencer
`timescale 1ns / 100ps

module tb_uart_bootloader_host_sequencer_top;
  import ubhs_pkg::*;

  localparam int unsigned CycleLimit  = 800_000;
  localparam int unsigned DrainCycles = 20;   // covers words still in flight after a silent one
  localparam int unsigned PhaseWords  = 100;

  localparam logic [1:0] CMD_INVALID = 2'd3;
  localparam logic [3:0] OP_BEYOND   = 4'd15;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  ubhs_chan_if #(.payload_t(in_item_t))  in_chan ();
  ubhs_chan_if #(.payload_t(out_item_t)) out_chan ();
  ubhs_chan_if #(.payload_t(cfg_item_t)) cfg_chan ();

  int unsigned mismatches;
  int unsigned pending;
  int unsigned checked;

  logic [7:0]  ack_now = ACK_RESET;
  int unsigned words_sent = 0;
  int unsigned cfg_writes = 0;
  bit          gaps_on    = 1'b0;
  bit          noise_on   = 1'b0;
  logic        stalls_on  = 1'b0;
  logic        sink_ready = 1'b1;
  int unsigned stall_left = 0;

  uart_bootloader_host_sequencer_top dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  ubhs_result_checker u_result_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_chan.valid),
    .in_ready_i   (in_chan.ready),
    .in_word_i    (in_chan.payload),
    .out_valid_i  (out_chan.valid),
    .out_ready_i  (out_chan.ready),
    .out_word_i   (out_chan.payload),
    .cfg_valid_i  (cfg_chan.valid),
    .cfg_ready_i  (cfg_chan.ready),
    .cfg_ack_i    (cfg_chan.payload),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  always #5 clk_i = ~clk_i;

  // result side stalls in random bursts
  assign out_chan.ready = sink_ready;

  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      sink_ready <= (stall_left == 1);
    end else if (stalls_on && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(1, 17);
      sink_ready <= 1'b0;
    end
  end

  // give up if the run hangs
  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("CHECKS FAILED");
    $finish;
  end

  // hand one word to the block; valid stays high unless a gap follows
  task automatic send_word(input in_item_t w);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    in_chan.valid   <= 1'b1;
    in_chan.payload <= w;
    do @(posedge clk_i); while (!in_chan.ready);
    words_sent++;
  endtask

  task automatic send_cmd(input logic [1:0] cmd, input logic [3:0] op,
                          input logic [31:0] addr, input logic [7:0] cnt,
                          input logic [7:0] val);
    in_item_t w;
    w.command        = cmd;
    w.operation      = op;
    w.target_address = addr;
    w.byte_count     = cnt;
    w.byte_value     = val;
    send_word(w);
  endtask

  // now and then a word that the current phase does not accept
  task automatic stray_word(input bit tx_phase);
    if (noise_on && $urandom_range(0, 15) == 0) begin
      case ($urandom_range(0, 2))
        0: send_cmd(CMD_BEGIN, 4'($urandom), $urandom, 8'($urandom), 8'($urandom));
        1: send_cmd(CMD_INVALID, 4'($urandom), $urandom, 8'($urandom), 8'($urandom));
        default: send_cmd(tx_phase ? CMD_RX_BYTE : CMD_ADVANCE, 4'($urandom), $urandom,
                          8'($urandom), 8'($urandom));
      endcase
    end
  endtask

  task automatic rx_step(input logic [7:0] v);
    stray_word(1'b0);
    send_cmd(CMD_RX_BYTE, 4'($urandom), $urandom, 8'($urandom), v);
  endtask

  task automatic adv_step(input logic [7:0] v);
    stray_word(1'b1);
    send_cmd(CMD_ADVANCE, 4'($urandom), $urandom, 8'($urandom), v);
  endtask

  // acknowledge number k of an operation; the one picked by nack_at is refused
  task automatic ack_step(input int unsigned k, input int unsigned nack_at, output bit ok);
    logic [7:0] b;
    ok = (k != nack_at);
    if (ok) begin
      b = ack_now;
    end else begin
      do b = 8'($urandom); while (b == ack_now);
    end
    rx_step(b);
  endtask

  // mostly short transfers, once in a while any length
  function automatic logic [7:0] pick_len();
    if ($urandom_range(0, 15) == 0) return 8'($urandom);
    return 8'($urandom_range(0, 5));
  endfunction

  // one operation as the host runs it; nack_at picks the refused acknowledge, 0 for none
  task automatic run_op(input logic [3:0] op, input logic [31:0] addr,
                        input logic [7:0] cnt, input int unsigned nack_at);
    int unsigned n;
    logic [7:0]  rx_cnt;
    bit          ok;
    send_cmd(CMD_BEGIN, op, addr, cnt, 8'($urandom));
    ack_step(1, nack_at, ok);
    if (!ok) return;
    case (op)
      OP_SYNC: ;
      OP_GET, OP_GETID: begin
        rx_cnt = pick_len();
        rx_step(rx_cnt);
        for (n = 0; n <= rx_cnt; n++) rx_step(8'($urandom));
        ack_step(2, nack_at, ok);
      end
      OP_GETVER: begin
        for (n = 0; n < 3; n++) rx_step(8'($urandom));
        ack_step(2, nack_at, ok);
      end
      OP_READ: begin
        ack_step(2, nack_at, ok);
        if (ok) ack_step(3, nack_at, ok);
        if (ok) for (n = 0; n <= cnt; n++) rx_step(8'($urandom));
      end
      OP_WRITE: begin
        ack_step(2, nack_at, ok);
        if (ok) begin
          for (n = 0; n <= cnt; n++) adv_step(8'($urandom));
          ack_step(3, nack_at, ok);
        end
      end
      OP_ERASE: begin
        if (cnt != GLOBAL_ERASE_CNT) for (n = 0; n <= cnt; n++) adv_step(8'($urandom));
        ack_step(2, nack_at, ok);
      end
      default: ack_step(2, nack_at, ok);
    endcase
  endtask

  // words that an idle block must refuse
  task automatic idle_noise();
    case ($urandom_range(0, 3))
      0: send_cmd(CMD_BEGIN, 4'($urandom_range(OP_LAST + 1, OP_BEYOND)), $urandom,
                  8'($urandom), 8'($urandom));
      1: send_cmd(CMD_INVALID, 4'($urandom), $urandom, 8'($urandom), 8'($urandom));
      2: send_cmd(CMD_RX_BYTE, 4'($urandom), $urandom, 8'($urandom), 8'($urandom));
      default: send_cmd(CMD_ADVANCE, 4'($urandom), $urandom, 8'($urandom), 8'($urandom));
    endcase
  endtask

  // hold the sender until every predicted word has left, plus the latency allowance
  task automatic drain_all();
    in_chan.valid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_ack(input logic [7:0] v);
    drain_all();
    cfg_chan.valid   <= 1'b1;
    cfg_chan.payload <= v;
    do @(posedge clk_i); while (!cfg_chan.ready);
    cfg_chan.valid <= 1'b0;
    ack_now = v;
    cfg_writes++;
  endtask

  // mostly well-formed operations with random content, some refused acks and noise
  task automatic random_run(input int unsigned word_goal);
    int unsigned start;
    logic [3:0]  op;
    logic [7:0]  cnt;
    int unsigned nack_at;
    start = words_sent;
    while (words_sent - start < word_goal) begin
      if ($urandom_range(0, 9) == 0) begin
        idle_noise();
      end else begin
        op  = 4'($urandom_range(OP_SYNC, OP_LAST));
        cnt = pick_len();
        if (op == OP_ERASE && $urandom_range(0, 4) == 0) cnt = GLOBAL_ERASE_CNT;
        nack_at = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0;
        run_op(op, $urandom, cnt, nack_at);
      end
    end
  endtask

  initial begin
    bit ok;
    in_chan.valid    = 1'b0;
    in_chan.payload  = '0;
    cfg_chan.valid   = 1'b0;
    cfg_chan.payload = ACK_RESET;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed part at the reset ack value
    gaps_on   = 1'b1;
    stalls_on <= 1'b1;
    run_op(OP_SYNC, '0, '0, 0);
    send_cmd(CMD_BEGIN, OP_BEYOND, '1, '1, '1);
    send_cmd(CMD_INVALID, '0, '0, '0, '0);
    send_cmd(CMD_RX_BYTE, '0, '0, '0, ACK_RESET);
    send_cmd(CMD_ADVANCE, '1, '1, '1, '1);
    run_op(OP_GET, '0, '0, 1);
    run_op(OP_GETVER, '1, '1, 0);
    run_op(OP_GETID, '0, '0, 2);
    run_op(OP_READ, '1, '0, 0);
    // go at address zero wraps below zero
    run_op(OP_GO, '0, '0, 0);
    // write with a received byte during the payload
    send_cmd(CMD_BEGIN, OP_WRITE, 32'h8000_0001, '0, '0);
    ack_step(1, 0, ok);
    ack_step(2, 0, ok);
    send_cmd(CMD_RX_BYTE, '1, '1, '1, ack_now);
    adv_step('1);
    ack_step(3, 3, ok);
    // global erase, then a two page erase
    run_op(OP_ERASE, '0, GLOBAL_ERASE_CNT, 0);
    run_op(OP_ERASE, '1, 8'd1, 0);
    // unprotect with a begin and an advance while busy
    send_cmd(CMD_BEGIN, OP_UNPROTECT, '0, '0, '0);
    send_cmd(CMD_BEGIN, OP_SYNC, '0, '0, '0);
    send_cmd(CMD_ADVANCE, '0, '0, '0, '0);
    ack_step(1, 0, ok);
    ack_step(2, 0, ok);

    // random phases over several ack values, extremes first
    noise_on = 1'b1;
    write_ack(8'h00);
    random_run(PhaseWords);
    write_ack(8'hFF);
    random_run(PhaseWords / 2);
    drain_all();
    random_run(PhaseWords / 2);
    write_ack(8'($urandom));
    random_run(PhaseWords);

    // last part runs back to back
    gaps_on   = 1'b0;
    stalls_on <= 1'b0;
    write_ack(ACK_RESET);
    random_run(PhaseWords);

    drain_all();
    @(negedge clk_i);
    $display("run covered %0d input words and %0d ack settings, with nacks and stray words",
             words_sent, cfg_writes + 1);
    $display("%0d result words compared, %0d mismatches", checked, mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
